// ----- src/mac_frame_header_parser_assert.svh -----
// assertion macros shared by the header parser modules
`ifndef MAC_FRAME_HEADER_PARSER_ASSERT_SVH
`define MAC_FRAME_HEADER_PARSER_ASSERT_SVH

// same-cycle implication, checked on every clk edge outside reset
`define MFHP_ASSERT_NOW(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// next-cycle implication
`define MFHP_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ----- src/mfhp_pkg.sv -----
// shared constants, result type and field length helpers for the header parser
package mfhp_pkg;

	localparam int MAX_FRAME_BYTES = 2047;
	localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam int DIFF_W = (POS_W + 2 > 12) ? POS_W + 2 : 12;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_TRUNCATED = 2'd1;
	localparam logic [1:0] STATUS_SECURITY  = 2'd2;

	localparam logic [1:0] ADDR_MODE_NONE  = 2'd0;
	localparam logic [1:0] ADDR_MODE_SHORT = 2'd2;

	localparam int FC_SECURITY_BIT = 3;
	localparam int FC_PAN_COMP_BIT = 6;
	localparam int FC_DST_MODE_LSB = 10;
	localparam int FC_SRC_MODE_LSB = 14;

	localparam logic [4:0] FIXED_HEADER_BYTES = 5'd3;
	localparam logic [4:0] FCS_BYTES = 5'd2;
	localparam logic [7:0] PAYLOAD_MAX = 8'hff;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] frame_control;
		logic [7:0]  seq_number;
		logic [15:0] dst_pan;
		logic [63:0] dst_address;
		logic [15:0] src_pan;
		logic [63:0] src_address;
		logic [4:0]  header_length;
		logic [10:0] payload_length;
		logic        payload_in_range;
		logic [15:0] frame_check;
	} header_result_t;

	function automatic logic [3:0] addr_bytes(input logic [1:0] mode);
		logic [3:0] n;
		case (mode)
			ADDR_MODE_NONE: n = 4'd0;
			ADDR_MODE_SHORT: n = 4'd2;
			default: n = 4'd8;
		endcase
		return n;
	endfunction

	function automatic logic [1:0] dst_mode(input logic [15:0] fc);
		return fc[FC_DST_MODE_LSB +: 2];
	endfunction

	function automatic logic [1:0] src_mode(input logic [15:0] fc);
		return fc[FC_SRC_MODE_LSB +: 2];
	endfunction

	function automatic logic [3:0] dst_len(input logic [15:0] fc);
		return (dst_mode(fc) != ADDR_MODE_NONE) ? 4'd2 + addr_bytes(dst_mode(fc)) : 4'd0;
	endfunction

	function automatic logic [3:0] src_pan_len(input logic [15:0] fc);
		return (src_mode(fc) != ADDR_MODE_NONE && !fc[FC_PAN_COMP_BIT]) ? 4'd2 : 4'd0;
	endfunction

	function automatic logic [3:0] src_len(input logic [15:0] fc);
		return (src_mode(fc) != ADDR_MODE_NONE) ?
			src_pan_len(fc) + addr_bytes(src_mode(fc)) : 4'd0;
	endfunction

endpackage

// ----- src/mfhp_header_state.sv -----
// header capture registers, byte position counter and end-of-frame result logic
`include "mac_frame_header_parser_assert.svh"

module mfhp_header_state (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  logic [7:0]              rx_byte,
	input  logic                    end_of_frame,
	output mfhp_pkg::header_result_t result
);
	import mfhp_pkg::*;

	logic [POS_W-1:0] pos_q, pos_nx;
	logic [15:0] cw_q, cw_nx;
	logic [7:0]  seq_q, seq_nx;
	logic [15:0] dpan_q, dpan_nx;
	logic [63:0] daddr_q, daddr_nx;
	logic [15:0] span_q, span_nx;
	logic [63:0] saddr_q, saddr_nx;
	logic [15:0] ltb_q, ltb_nx;

	logic [3:0] dl, sl, sp;
	logic [3:0] dl_f, sl_f;
	logic [POS_W-1:0] off;
	logic [4:0] lane_d, lane_s, lane_sa;
	logic is_field, hit_dst, hit_src;
	logic [POS_W-1:0] size;
	logic [4:0] hdr_f;
	logic [DIFF_W-1:0] diff;
	logic trunc, ok;
	logic [1:0] stat;

	// field capture, lengths from the control word as it stands
	always_comb begin
		dl = dst_len(cw_q);
		sl = src_len(cw_q);
		sp = src_pan_len(cw_q);
		is_field = pos_q >= POS_W'(3);
		off = pos_q - POS_W'(3);
		hit_dst = is_field && (off < POS_W'(dl));
		hit_src = is_field && !hit_dst && (off < POS_W'(dl) + POS_W'(sl));
		lane_d = off[4:0];
		lane_s = lane_d - {1'b0, dl};
		lane_sa = lane_s - {1'b0, sp};

		cw_nx = cw_q;
		seq_nx = seq_q;
		if (pos_q == POS_W'(0)) begin
			cw_nx = {cw_q[15:8], rx_byte};
		end else if (pos_q == POS_W'(1)) begin
			cw_nx = {rx_byte, cw_q[7:0]};
		end else if (pos_q == POS_W'(2)) begin
			seq_nx = rx_byte;
		end

		dpan_nx = dpan_q;
		daddr_nx = daddr_q;
		span_nx = span_q;
		saddr_nx = saddr_q;
		for (int k = 0; k < 2; k++) begin
			if (hit_dst && lane_d == 5'(k))
				dpan_nx[8*k +: 8] = dpan_q[8*k +: 8] | rx_byte;
			if (hit_src && lane_s < {1'b0, sp} && lane_s == 5'(k))
				span_nx[8*k +: 8] = span_q[8*k +: 8] | rx_byte;
		end
		for (int k = 0; k < 8; k++) begin
			if (hit_dst && lane_d >= 5'd2 && (lane_d - 5'd2) == 5'(k))
				daddr_nx[8*k +: 8] = daddr_q[8*k +: 8] | rx_byte;
			if (hit_src && lane_s >= {1'b0, sp} && lane_sa == 5'(k))
				saddr_nx[8*k +: 8] = saddr_q[8*k +: 8] | rx_byte;
		end

		ltb_nx = {ltb_q[7:0], rx_byte};
		pos_nx = (pos_q < POS_W'(MAX_FRAME_BYTES)) ? pos_q + POS_W'(1) : pos_q;
	end

	// end-of-frame result, from the state after this byte
	always_comb begin
		dl_f = dst_len(cw_nx);
		sl_f = src_len(cw_nx);
		size = (pos_q == POS_W'(MAX_FRAME_BYTES)) ? pos_q : pos_q + POS_W'(1);
		hdr_f = FIXED_HEADER_BYTES + 5'(dl_f) + 5'(sl_f);
		trunc = {1'b0, size} < (POS_W+1)'(FIXED_HEADER_BYTES + 5'(dl_f));
		if (trunc)
			stat = STATUS_TRUNCATED;
		else if (cw_nx[FC_SECURITY_BIT])
			stat = STATUS_SECURITY;
		else
			stat = STATUS_OK;
		ok = stat == STATUS_OK;
		diff = DIFF_W'(size) - DIFF_W'(hdr_f) - DIFF_W'(FCS_BYTES);

		result.status = stat;
		result.frame_control = cw_nx;
		result.seq_number = seq_nx;
		result.dst_pan = dpan_nx;
		result.dst_address = daddr_nx;
		result.src_pan = (src_mode(cw_nx) != ADDR_MODE_NONE && cw_nx[FC_PAN_COMP_BIT]) ?
			dpan_nx : span_nx;
		result.src_address = saddr_nx;
		result.header_length = ok ? hdr_f : 5'd0;
		result.payload_length = ok ? diff[10:0] : 11'd0;
		result.payload_in_range = ok && !diff[DIFF_W-1] &&
			(diff[DIFF_W-2:0] <= (DIFF_W-1)'(PAYLOAD_MAX));
		result.frame_check = ok ? ltb_nx : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			cw_q <= '0;
			seq_q <= '0;
			dpan_q <= '0;
			daddr_q <= '0;
			span_q <= '0;
			saddr_q <= '0;
			ltb_q <= '0;
		end else if (step) begin
			if (end_of_frame) begin
				pos_q <= '0;
				cw_q <= '0;
				seq_q <= '0;
				dpan_q <= '0;
				daddr_q <= '0;
				span_q <= '0;
				saddr_q <= '0;
				ltb_q <= '0;
			end else begin
				pos_q <= pos_nx;
				cw_q <= cw_nx;
				seq_q <= seq_nx;
				dpan_q <= dpan_nx;
				daddr_q <= daddr_nx;
				span_q <= span_nx;
				saddr_q <= saddr_nx;
				ltb_q <= ltb_nx;
			end
		end
	end

	`MFHP_ASSERT_NOW(a_pos_bound, 1'b1, pos_q <= POS_W'(MAX_FRAME_BYTES), "byte position overran")
	`MFHP_ASSERT_NEXT(a_frame_clear, step && end_of_frame, pos_q == '0 && cw_q == '0, "state not cleared")
	`MFHP_ASSERT_NOW(a_short_dst, dst_mode(cw_q) == ADDR_MODE_SHORT, daddr_q[63:16] == '0, "short dst overflow")

endmodule

// ----- src/mac_frame_header_parser.sv -----
// top level of the 802.15.4 mac frame header parser: handshake, input and result registers
//
// usage
//   input channel: one frame byte per item on rx_byte, end_of_frame high on the last byte
//   an item moves when in_valid is high and in_stall is low at a rising clk edge
//   output channel: one result item per frame, presented on out_valid with all header fields
//   a result moves when out_valid is high and out_stall is low
// throughput: one byte per cycle unless a last byte waits for the result register;
//   the byte counter and field capture update as each byte leaves the input register
// path: a last byte passes through the input register, then the result register
// stall: a waiting result holds in the output register; bytes that are not the last
//   keep flowing under it, and only a last byte waits for the output register to free up
// reset: arst_n low clears the byte counter, all captured fields and both valid flags;
//   the first byte after reset is byte zero of a frame
// status: truncated when the frame ends inside the fixed header or destination fields,
//   else security when the control word asks for it; both zero the lengths and check word
`include "mac_frame_header_parser_assert.svh"

module mac_frame_header_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        end_of_frame,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] frame_control,
	output logic [7:0]  seq_number,
	output logic [15:0] dst_pan,
	output logic [63:0] dst_address,
	output logic [15:0] src_pan,
	output logic [63:0] src_address,
	output logic [4:0]  header_length,
	output logic [10:0] payload_length,
	output logic        payload_in_range,
	output logic [15:0] frame_check
);
	import mfhp_pkg::*;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eof_s1;

	// result register
	logic           out_valid_q;
	header_result_t result_q;
	header_result_t result;

	logic out_free;
	logic advance;
	logic accept;

	// a last byte needs the result register; other bytes never do
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && (!eof_s1 || out_free);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= rx_byte;
			eof_s1 <= end_of_frame;
		end
	end

	// capture state and result logic
	mfhp_header_state u_state (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.rx_byte      (byte_s1),
		.end_of_frame (eof_s1),
		.result       (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && eof_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && eof_s1) begin
			result_q <= result;
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = result_q.status;
	assign frame_control    = result_q.frame_control;
	assign seq_number       = result_q.seq_number;
	assign dst_pan          = result_q.dst_pan;
	assign dst_address      = result_q.dst_address;
	assign src_pan          = result_q.src_pan;
	assign src_address      = result_q.src_address;
	assign header_length    = result_q.header_length;
	assign payload_length   = result_q.payload_length;
	assign payload_in_range = result_q.payload_in_range;
	assign frame_check      = result_q.frame_check;

	`MFHP_ASSERT_NOW(a_err_zero, out_valid_q && result_q.status != STATUS_OK, result_q.header_length == '0 && result_q.frame_check == '0 && !result_q.payload_in_range, "error result not zeroed")
	`MFHP_ASSERT_NOW(a_hdr_min, out_valid_q && result_q.status == STATUS_OK, result_q.header_length >= FIXED_HEADER_BYTES, "header shorter than fixed part")
	`MFHP_ASSERT_NOW(a_no_src, out_valid_q && src_mode(result_q.frame_control) == ADDR_MODE_NONE, result_q.src_pan == '0 && result_q.src_address == '0, "source present without mode")
	`MFHP_ASSERT_NEXT(a_result_load, advance && eof_s1, out_valid_q, "result lost")

endmodule
